[design/bpd_pkg.sv]
// bpd_pkg: constants, types and symbol mapping for the bigram profile distance core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bpd_pkg;
   localparam int COUNT_BITS_DEFAULT = 20;
   localparam int SYMBOLS = 27;
   localparam int CELLS = SYMBOLS * SYMBOLS;
   localparam int CELL_BITS = $clog2(CELLS);
   localparam int SYM_BITS = 5;
   localparam logic [SYM_BITS-1:0] SPACE_SYM = 5'd26;
   localparam logic [SYM_BITS-1:0] NO_SYM = 5'd27;
   localparam int FRAC_BITS = 16;
   localparam int DIST_BITS = 18;
   localparam logic [DIST_BITS-1:0] DIST_MAX = 18'd131072;

   typedef enum logic [1:0] {
      CMD_REF   = 2'd0,
      CMD_CAND  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR_ALL,
      ST_IDLE,
      ST_BUMP,
      ST_TRAIL,
      ST_CLEAR_REF,
      ST_DIST_READ,
      ST_DIST_WAIT,
      ST_DIV_R,
      ST_DIV_C,
      ST_ACCUM,
      ST_DONE
   } state_type;

   function automatic logic [SYM_BITS-1:0] map_char(input logic [7:0] c);
      logic [SYM_BITS-1:0] s;
      s = NO_SYM;
      if (c >= 8'h61 && c <= 8'h7a) s = SYM_BITS'(c - 8'h61);
      else if (c == 8'h20 || c == 8'h0a) s = SPACE_SYM;
      return s;
   endfunction
endpackage
`default_nettype wire

[design/bigram_profile_distance_core.sv]
// bigram_profile_distance_core: bigram histograms and fixed-point l1 distance
// depends on bpd_pkg
`timescale 1ns / 1ps
`default_nettype none
// Items are taken when start is high and busy low. A character that forms a pair goes
// through accept, read and write back on the single-port count memories; the trailing
// pair at the end of a text adds another read and write back, and the end of a text
// passes through a trailing state. A character that forms no pair is only accepted, or at
// the end of a text also passes through the trailing state. At the end of a candidate
// text the distance is computed cell by cell through one shared restoring divider of 17
// steps, run once for each table, and each candidate cell is cleared as it is used. If
// either text has no pairs the candidate table is cleared instead in a sweep. A clear
// command sweeps the reference table. After reset both tables are cleared in a pass during
// which busy is high. The result strobe rsp_valid lasts one cycle and cannot be stalled.
module bigram_profile_distance_core #(
   parameter int COUNT_BITS = bpd_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [7:0]                    req_ch,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   output logic [bpd_pkg::DIST_BITS-1:0]      rsp_distance,
   output logic                               rsp_empty_text
);
   localparam int CB = bpd_pkg::CELL_BITS;
   localparam int DW = COUNT_BITS;
   localparam int QW = bpd_pkg::FRAC_BITS + 1;
   localparam int SW = bpd_pkg::DIST_BITS + 14;
   localparam int PW = 2 * bpd_pkg::SYM_BITS;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] ref_mem [bpd_pkg::CELLS];
   logic [COUNT_BITS-1:0] cand_mem [bpd_pkg::CELLS];
   logic [COUNT_BITS-1:0] ref_rd_ff, cand_rd_ff;

   bpd_pkg::state_type state_ff, state_in;
   logic [CB-1:0] addr_ff, addr_in;
   logic cand_ff, cand_in, last_ff, last_in;
   logic [bpd_pkg::SYM_BITS-1:0] prev_ff, prev_in, sym_ff, sym_in;
   logic have_prev_ff, have_prev_in;
   logic [COUNT_BITS-1:0] ref_tot_ff, ref_tot_in, cand_tot_ff, cand_tot_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in, fr_ff, fr_in;
   logic [4:0] step_ff, step_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [bpd_pkg::DIST_BITS-1:0] dist_ff, dist_in;
   logic empty_ff, empty_in, valid_ff, valid_in;
   logic ref_we, cand_we;
   logic [COUNT_BITS-1:0] ref_wd, cand_wd;
   logic [COUNT_BITS-1:0] divisor;
   logic [bpd_pkg::SYM_BITS-1:0] in_sym;
   logic [PW-1:0] pair_idx;

   always_ff @(posedge clock) begin
      if (ref_we) ref_mem[addr_ff] <= ref_wd;
      if (cand_we) cand_mem[addr_ff] <= cand_wd;
      ref_rd_ff <= ref_mem[addr_ff];
      cand_rd_ff <= cand_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpd_pkg::ST_CLEAR_ALL;
         addr_ff <= '0;
         have_prev_ff <= 1'b0;
         prev_ff <= '0;
         ref_tot_ff <= '0;
         cand_tot_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         have_prev_ff <= have_prev_in;
         prev_ff <= prev_in;
         ref_tot_ff <= ref_tot_in;
         cand_tot_ff <= cand_tot_in;
         valid_ff <= valid_in;
      end
      cand_ff <= cand_in;
      last_ff <= last_in;
      sym_ff <= sym_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      fr_ff <= fr_in;
      step_ff <= step_in;
      sum_ff <= sum_in;
      dist_ff <= dist_in;
      empty_ff <= empty_in;
   end

   assign divisor = (state_ff == bpd_pkg::ST_DIV_R) ? ref_tot_ff : cand_tot_ff;
   assign in_sym = bpd_pkg::map_char(req_ch);

   always_comb begin
      logic [DW:0] sh;
      logic [DW:0] dv;
      logic [QW-1:0] d;
      state_in = state_ff;
      addr_in = addr_ff;
      cand_in = cand_ff;
      last_in = last_ff;
      sym_in = sym_ff;
      prev_in = prev_ff;
      have_prev_in = have_prev_ff;
      ref_tot_in = ref_tot_ff;
      cand_tot_in = cand_tot_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      fr_in = fr_ff;
      step_in = step_ff;
      sum_in = sum_ff;
      dist_in = dist_ff;
      empty_in = empty_ff;
      valid_in = 1'b0;
      ref_we = 1'b0;
      cand_we = 1'b0;
      ref_wd = '0;
      cand_wd = '0;
      busy = 1'b1;
      pair_idx = '0;
      sh = '0;
      dv = '0;
      d = '0;
      case (state_ff)
         bpd_pkg::ST_CLEAR_ALL: begin
            ref_we = 1'b1;
            cand_we = 1'b1;
            if (addr_ff == CB'(bpd_pkg::CELLS - 1)) begin
               addr_in = '0;
               state_in = bpd_pkg::ST_IDLE;
            end else addr_in = addr_ff + 1'b1;
         end
         bpd_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cand_in = (req_cmd == bpd_pkg::CMD_CAND);
               last_in = req_last;
               sym_in = in_sym;
               if (req_cmd == bpd_pkg::CMD_CLEAR) begin
                  have_prev_in = 1'b0;
                  ref_tot_in = '0;
                  addr_in = '0;
                  state_in = bpd_pkg::ST_CLEAR_REF;
               end else if (req_cmd != bpd_pkg::CMD_NONE) begin
                  if (in_sym != bpd_pkg::NO_SYM) begin
                     prev_in = in_sym;
                     have_prev_in = 1'b1;
                  end
                  if (in_sym != bpd_pkg::NO_SYM && have_prev_ff &&
                      !(prev_ff == bpd_pkg::SPACE_SYM && in_sym == bpd_pkg::SPACE_SYM)) begin
                     pair_idx = PW'(prev_ff) * PW'(bpd_pkg::SYMBOLS) + PW'(in_sym);
                     addr_in = CB'(pair_idx);
                     step_in = 5'd31;
                     state_in = bpd_pkg::ST_DIST_WAIT;
                  end else if (req_last) begin
                     sym_in = bpd_pkg::NO_SYM;
                     if ((in_sym != bpd_pkg::NO_SYM || have_prev_ff) &&
                         ((in_sym != bpd_pkg::NO_SYM ? in_sym : prev_ff)
                          != bpd_pkg::SPACE_SYM)) begin
                        pair_idx = PW'(in_sym != bpd_pkg::NO_SYM ? in_sym : prev_ff)
                                   * PW'(bpd_pkg::SYMBOLS) + PW'(bpd_pkg::SPACE_SYM);
                        addr_in = CB'(pair_idx);
                        step_in = 5'd31;
                        state_in = bpd_pkg::ST_DIST_WAIT;
                     end else state_in = bpd_pkg::ST_TRAIL;
                  end
               end
            end
         end
         bpd_pkg::ST_BUMP: begin
            // read data valid now; write back
            if (cand_ff) begin
               cand_we = 1'b1;
               cand_wd = (cand_rd_ff == CMAX) ? cand_rd_ff : cand_rd_ff + 1'b1;
               if (cand_tot_ff != CMAX) cand_tot_in = cand_tot_ff + 1'b1;
            end else begin
               ref_we = 1'b1;
               ref_wd = (ref_rd_ff == CMAX) ? ref_rd_ff : ref_rd_ff + 1'b1;
               if (ref_tot_ff != CMAX) ref_tot_in = ref_tot_ff + 1'b1;
            end
            if (!last_ff) state_in = bpd_pkg::ST_IDLE;
            else if (sym_ff != bpd_pkg::NO_SYM && sym_ff != bpd_pkg::SPACE_SYM) begin
               pair_idx = PW'(sym_ff) * PW'(bpd_pkg::SYMBOLS) + PW'(bpd_pkg::SPACE_SYM);
               sym_in = bpd_pkg::NO_SYM;
               state_in = bpd_pkg::ST_TRAIL;
            end else begin
               sym_in = bpd_pkg::NO_SYM;
               state_in = bpd_pkg::ST_TRAIL;
            end
            if (pair_idx != '0) begin
               addr_in = CB'(pair_idx);
               state_in = bpd_pkg::ST_DIST_WAIT;
               step_in = 5'd31;
            end
         end
         bpd_pkg::ST_TRAIL: begin
            have_prev_in = 1'b0;
            if (!cand_ff) state_in = bpd_pkg::ST_IDLE;
            else begin
               empty_in = (ref_tot_ff == '0) || (cand_tot_ff == '0);
               sum_in = '0;
               addr_in = '0;
               state_in = ((ref_tot_ff == '0) || (cand_tot_ff == '0)) ?
                          bpd_pkg::ST_DONE : bpd_pkg::ST_DIST_READ;
            end
         end
         bpd_pkg::ST_CLEAR_REF: begin
            ref_we = 1'b1;
            if (addr_ff == CB'(bpd_pkg::CELLS - 1)) begin
               addr_in = '0;
               state_in = bpd_pkg::ST_IDLE;
            end else addr_in = addr_ff + 1'b1;
         end
         bpd_pkg::ST_DIST_READ: begin
            step_in = '0;
            state_in = bpd_pkg::ST_DIST_WAIT;
         end
         bpd_pkg::ST_DIST_WAIT: begin
            // pair bumps share this wait for their read
            if (step_ff == 5'd31) state_in = bpd_pkg::ST_BUMP;
            else begin
               rem_in = DW'(ref_rd_ff);
               quo_in = '0;
               step_in = '0;
               state_in = bpd_pkg::ST_DIV_R;
            end
         end
         bpd_pkg::ST_DIV_R, bpd_pkg::ST_DIV_C: begin
            // restoring division of cell*2^16 by total, one quotient bit per step
            sh = (step_ff == 5'd0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
            dv = {1'b0, divisor};
            if (sh >= dv) begin
               rem_in = DW'(sh - dv);
               d = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = DW'(sh);
               d = {quo_ff[QW-2:0], 1'b0};
            end
            quo_in = d;
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(bpd_pkg::FRAC_BITS)) begin
               if (state_ff == bpd_pkg::ST_DIV_R) begin
                  fr_in = d;
                  rem_in = DW'(cand_rd_ff);
                  quo_in = '0;
                  step_in = '0;
                  state_in = bpd_pkg::ST_DIV_C;
               end else state_in = bpd_pkg::ST_ACCUM;
            end
         end
         bpd_pkg::ST_ACCUM: begin
            cand_we = 1'b1;
            sum_in = sum_ff + SW'((fr_ff >= quo_ff) ? fr_ff - quo_ff : quo_ff - fr_ff);
            if (addr_ff == CB'(bpd_pkg::CELLS - 1)) begin
               state_in = bpd_pkg::ST_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
               state_in = bpd_pkg::ST_DIST_READ;
            end
         end
         bpd_pkg::ST_DONE: begin
            if (empty_ff) begin
               cand_we = 1'b1;
               dist_in = '0;
               if (addr_ff == CB'(bpd_pkg::CELLS - 1)) begin
                  addr_in = '0;
                  cand_tot_in = '0;
                  valid_in = 1'b1;
                  state_in = bpd_pkg::ST_IDLE;
               end else addr_in = addr_ff + 1'b1;
            end else begin
               dist_in = (sum_ff > SW'(bpd_pkg::DIST_MAX)) ? bpd_pkg::DIST_MAX
                         : sum_ff[bpd_pkg::DIST_BITS-1:0];
               addr_in = '0;
               cand_tot_in = '0;
               valid_in = 1'b1;
               state_in = bpd_pkg::ST_IDLE;
            end
         end
         default: state_in = bpd_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_distance = dist_ff;
   assign rsp_empty_text = empty_ff;

`ifndef SYNTHESIS
   a_no_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("double result strobe");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_text) |-> (rsp_distance == '0))
      else $error("empty text with distance");
   a_dist_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance <= bpd_pkg::DIST_MAX)) else $error("distance over cap");
`endif
endmodule
`default_nettype wire
